FILE: rtl/interval_map_range_assign_defines.svh
// Assertion macros shared by the interval map RTL.
`ifndef INTERVAL_MAP_RANGE_ASSIGN_DEFINES_SVH
`define INTERVAL_MAP_RANGE_ASSIGN_DEFINES_SVH
`ifndef SYNTH
`define IMA_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define IMA_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IMA_ASSERT_IMP(name, ante, cons, msg)
`define IMA_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

FILE: rtl/ima_pkg.sv
// Shared types and constants of the interval map.
package ima_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 32;
   localparam int VAL_W        = 8;
   localparam int STAT_W       = 2;
   localparam int USED_OUT_W   = 7;

   localparam logic [VAL_W-1:0] DEFAULT_RESET = 8'd35;

   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_DEL,
      OP_INS
   } op_kind_type;

   // Broadcast to every cell: what to do this cycle and what to insert
   typedef struct packed {
      op_kind_type             kind;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        value;
   } cell_op_type;

   typedef struct packed {
      logic lt;
      logic le;
   } cell_flag_type;

endpackage

FILE: rtl/ima_cell.sv
// One breakpoint cell of the sorted chain: holds a key and value, shifts with neighbors.
module ima_cell #(
   parameter int IDX = 0,
   parameter int IW  = 6
) (
   input  logic                             clock,
   input  ima_pkg::cell_op_type             op,
   input  logic [IW-1:0]                    pos,
   input  logic signed [ima_pkg::KEY_W-1:0] left_key,
   input  logic [ima_pkg::VAL_W-1:0]        left_value,
   input  logic signed [ima_pkg::KEY_W-1:0] right_key,
   input  logic [ima_pkg::VAL_W-1:0]        right_value,
   input  logic signed [ima_pkg::KEY_W-1:0] lo_key,
   input  logic signed [ima_pkg::KEY_W-1:0] hi_key,
   output logic signed [ima_pkg::KEY_W-1:0] key,
   output logic [ima_pkg::VAL_W-1:0]        value,
   output ima_pkg::cell_flag_type           flag
);
   import ima_pkg::*;

   localparam logic [IW-1:0] MY_POS = IW'(IDX);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0]        value_ff, value_in;

   // Delete pulls from the right neighbor, insert pushes to the right
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      unique case (op.kind)
         OP_DEL: begin
            if (MY_POS >= pos) begin
               key_in   = right_key;
               value_in = right_value;
            end
         end
         OP_INS: begin
            if (MY_POS == pos) begin
               key_in   = op.key;
               value_in = op.value;
            end else if (MY_POS > pos) begin
               key_in   = left_key;
               value_in = left_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   // Compare against the broadcast range bounds
   assign flag.lt = key_ff < lo_key;
   assign flag.le = key_ff <= hi_key;
   assign key     = key_ff;
   assign value   = value_ff;

endmodule

FILE: rtl/interval_map_range_assign.sv
// Interval map with canonical range assign: a lookup passes through the
// evaluate and done states; an assign passes through evaluate, plan, one
// table shift per breakpoint removed inside [range_begin, range_end] plus
// at most two inserts and two merge removals, and done; the cell chain
// moves one place a cycle. An empty range goes straight to the done state.
// The result register lets a finished word wait while the block returns
// to idle.
`include "interval_map_range_assign_defines.svh"
module interval_map_range_assign #(
   parameter int CAPACITY = ima_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic signed [ima_pkg::KEY_W-1:0]  req_range_begin,
   input  logic signed [ima_pkg::KEY_W-1:0]  req_range_end,
   input  logic [ima_pkg::VAL_W-1:0]         req_new_value,
   input  logic signed [ima_pkg::KEY_W-1:0]  req_query_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ima_pkg::VAL_W-1:0]         rsp_found_value,
   output logic [ima_pkg::STAT_W-1:0]        rsp_status,
   output logic [ima_pkg::USED_OUT_W-1:0]    rsp_breakpoints_used,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ima_pkg::VAL_W-1:0]         csr_default_value
);
   import ima_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NW = CW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_PLAN,
      S_OPS,
      S_DONE
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           used_ff;
   logic [VAL_W-1:0]        default_ff;
   logic                    kind_ff;
   logic signed [KEY_W-1:0] b_ff, e_ff;
   logic [VAL_W-1:0]        val_ff;
   logic [CW-1:0]           lcnt_ff, pcnt_ff, del_cnt_ff;
   logic [VAL_W-1:0]        last_l_ff, end_ff, r0_ff, head_ff;
   logic                    r0_has_ff;
   logic                    do_l0_ff, do_r0_ff, ins_e_ff, ins_b_ff;
   logic [IW-1:0]           r0_pos_ff, mid_pos_ff;
   logic [VAL_W-1:0]        found_ff;
   logic [STAT_W-1:0]       status_ff;
   logic                    rsp_valid_ff;
   logic [VAL_W-1:0]        rsp_found_ff;
   logic [STAT_W-1:0]       rsp_status_ff;
   logic [USED_OUT_W-1:0]   rsp_used_ff;

   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [VAL_W-1:0]        cell_value [CAPACITY];
   cell_flag_type           cell_flag [CAPACITY];
   logic [CAPACITY-1:0]     valid_v, lt_v, le_v, lt_edge, le_edge, first_r;

   cell_op_type             cell_op;
   logic [IW-1:0]           cell_pos;

   // Build the chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int GL = (g == 0) ? 0 : g - 1;
      localparam int GR = (g == CAPACITY - 1) ? g : g + 1;

      ima_cell #(
         .IDX (g),
         .IW  (IW)
      ) u_cell (
         .clock       (clock),
         .op          (cell_op),
         .pos         (cell_pos),
         .left_key    (cell_key[GL]),
         .left_value  (cell_value[GL]),
         .right_key   (cell_key[GR]),
         .right_value (cell_value[GR]),
         .lo_key      (b_ff),
         .hi_key      (e_ff),
         .key         (cell_key[g]),
         .value       (cell_value[g]),
         .flag        (cell_flag[g])
      );

      assign valid_v[g] = CW'(g) < used_ff;
      assign lt_v[g]    = valid_v[g] && cell_flag[g].lt;
      assign le_v[g]    = valid_v[g] && cell_flag[g].le;

      // Mark the last cell below the begin, the last cell at or below the end and the first cell above the end
      if (g == CAPACITY - 1) begin : g_last
         assign lt_edge[g] = lt_v[g];
         assign le_edge[g] = le_v[g];
      end else begin : g_mid
         assign lt_edge[g] = lt_v[g] && !lt_v[g+1];
         assign le_edge[g] = le_v[g] && !le_v[g+1];
      end
      if (g == 0) begin : g_first
         assign first_r[g] = valid_v[g] && !le_v[g];
      end else begin : g_rest
         assign first_r[g] = valid_v[g] && !le_v[g] && le_v[g-1];
      end
   end

   // Encode boundaries and gather neighbor values
   logic [CW-1:0]    lcnt_c, pcnt_c;
   logic [VAL_W-1:0] last_l_c, end_edge_c, r0_c, end_c;
   logic             r0_has_c;

   always_comb begin
      lcnt_c     = '0;
      pcnt_c     = '0;
      last_l_c   = '0;
      end_edge_c = '0;
      r0_c       = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         lcnt_c     = lcnt_c | (lt_edge[i] ? CW'(i + 1) : '0);
         pcnt_c     = pcnt_c | (le_edge[i] ? CW'(i + 1) : '0);
         last_l_c   = last_l_c | (lt_edge[i] ? cell_value[i] : '0);
         end_edge_c = end_edge_c | (le_edge[i] ? cell_value[i] : '0);
         r0_c       = r0_c | (first_r[i] ? cell_value[i] : '0);
      end
      r0_has_c = |first_r;
      end_c    = (pcnt_c != '0) ? end_edge_c : default_ff;
   end

   // Decide merges and the new count
   logic             l0rm_c, l_kept_c, kb_c, ke_c, r0rm_c, full_c;
   logic [VAL_W-1:0] prev_b_c, prev_e_c, prev_r_c;
   logic [NW-1:0]    n_c;

   always_comb begin
      l0rm_c   = (lcnt_ff != '0) && (head_ff == default_ff);
      l_kept_c = (lcnt_ff > CW'(1)) || ((lcnt_ff == CW'(1)) && !l0rm_c);
      prev_b_c = l_kept_c ? last_l_ff : default_ff;
      kb_c     = val_ff != prev_b_c;
      prev_e_c = kb_c ? val_ff : prev_b_c;
      ke_c     = end_ff != prev_e_c;
      prev_r_c = ke_c ? end_ff : prev_e_c;
      r0rm_c   = r0_has_ff && (r0_ff == prev_r_c);
      n_c      = NW'(lcnt_ff) - NW'(l0rm_c) + NW'(kb_c) + NW'(ke_c)
               + NW'(used_ff) - NW'(pcnt_ff) - NW'(r0rm_c);
      full_c   = n_c > NW'(CAPACITY);
   end

   // Pick the chain step for this cycle
   always_comb begin
      cell_op.kind  = OP_HOLD;
      cell_op.key   = e_ff;
      cell_op.value = end_ff;
      cell_pos      = '0;
      if (state_ff == S_OPS) begin
         priority if (do_l0_ff) begin
            cell_op.kind = OP_DEL;
         end else if (do_r0_ff) begin
            cell_op.kind = OP_DEL;
            cell_pos     = r0_pos_ff;
         end else if (del_cnt_ff != '0) begin
            cell_op.kind = OP_DEL;
            cell_pos     = mid_pos_ff;
         end else if (ins_e_ff) begin
            cell_op.kind = OP_INS;
            cell_pos     = mid_pos_ff;
         end else if (ins_b_ff) begin
            cell_op.kind  = OP_INS;
            cell_op.key   = b_ff;
            cell_op.value = val_ff;
            cell_pos      = mid_pos_ff;
         end else begin
            cell_op.kind = OP_HOLD;
         end
      end
   end

   // Sequencer, table count, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         default_ff   <= DEFAULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            default_ff <= csr_default_value;
         end
         // Drop the result word once taken, unless a new one loads now
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  b_ff     <= req_range_begin;
                  e_ff     <= (req_kind == KIND_LOOKUP) ? req_query_key : req_range_end;
                  val_ff   <= req_new_value;
                  found_ff <= '0;
                  if (req_kind == KIND_ASSIGN && req_range_begin >= req_range_end) begin
                     status_ff <= ST_EMPTY;
                     state_ff  <= S_DONE;
                  end else begin
                     status_ff <= ST_DONE;
                     state_ff  <= S_EVAL;
                  end
               end
            end
            S_EVAL: begin
               lcnt_ff   <= lcnt_c;
               pcnt_ff   <= pcnt_c;
               last_l_ff <= last_l_c;
               end_ff    <= end_c;
               r0_ff     <= r0_c;
               r0_has_ff <= r0_has_c;
               head_ff   <= cell_value[0];
               if (kind_ff == KIND_LOOKUP) begin
                  found_ff <= end_c;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_PLAN;
               end
            end
            S_PLAN: begin
               if (full_c) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  do_l0_ff   <= l0rm_c;
                  do_r0_ff   <= r0rm_c;
                  del_cnt_ff <= pcnt_ff - lcnt_ff;
                  ins_e_ff   <= ke_c;
                  ins_b_ff   <= kb_c;
                  r0_pos_ff  <= IW'(pcnt_ff - CW'(l0rm_c));
                  mid_pos_ff <= IW'(lcnt_ff - CW'(l0rm_c));
                  used_ff    <= n_c[CW-1:0];
                  state_ff   <= S_OPS;
               end
            end
            S_OPS: begin
               priority if (do_l0_ff) begin
                  do_l0_ff <= 1'b0;
               end else if (do_r0_ff) begin
                  do_r0_ff <= 1'b0;
               end else if (del_cnt_ff != '0) begin
                  del_cnt_ff <= del_cnt_ff - CW'(1);
               end else if (ins_e_ff) begin
                  ins_e_ff <= 1'b0;
               end else if (ins_b_ff) begin
                  ins_b_ff <= 1'b0;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_found_ff  <= found_ff;
                  rsp_status_ff <= status_ff;
                  rsp_used_ff   <= USED_OUT_W'(used_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall            = state_ff != S_IDLE;
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found_value      = rsp_found_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_breakpoints_used = rsp_used_ff;

   `IMA_ASSERT_IMP(a_used_in_range, 1'b1, used_ff <= CW'(CAPACITY), "count above capacity")
   `IMA_ASSERT_NXT(a_reject_keeps_table, (state_ff == S_PLAN) && full_c, $stable(used_ff) && (status_ff == ST_FULL), "rejected assign changed table")
   `IMA_ASSERT_IMP(a_insert_in_table, cell_op.kind == OP_INS, CW'(mid_pos_ff) < used_ff, "insert beyond table end")
   `IMA_ASSERT_IMP(a_flag_no_value, rsp_valid_ff && (rsp_status_ff != ST_DONE), rsp_found_ff == '0, "flagged result carries value")

endmodule
